[hw/rtl/event_breakpoint_match_table_core_defines.svh]
// Assertion macros used by the breakpoint match table RTL.
`ifndef EVENT_BREAKPOINT_MATCH_TABLE_CORE_DEFINES_SVH
`define EVENT_BREAKPOINT_MATCH_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define EBMT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define EBMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ebmt_pkg.sv]
// Shared types and codes for the breakpoint match table.
package ebmt_pkg;

    // Operation codes carried in func.
    localparam logic [1:0] FN_CHECK  = 2'd0;
    localparam logic [1:0] FN_ARM    = 2'd1;
    localparam logic [1:0] FN_DISARM = 2'd2;
    localparam logic [1:0] FN_CLEAR  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Packet that travels along the cell chain. The first pass gathers
    // hit and duplicate information and performs removals; the second pass
    // performs the insertion and builds the armed mask.
    typedef struct packed {
        logic        pass2;
        logic [1:0]  func;
        logic [5:0]  event_id;
        logic [63:0] value;
        logic        hit;
        logic        dup;
        logic        claim;
        logic [63:0] mask;
    } pkt_t;

endpackage

[hw/rtl/event_breakpoint_match_table_core.sv]
// Each accepted input makes two passes along the chain of MAX_ENTRIES slot
// cells and then loads the result registers; a new input is taken only when
// the sequencer is idle, so only one packet is in the chain at a time.
// A new input is taken while the previous result still waits at the output.
// Reset (rst_n, asynchronous, active low) empties the table and zeroes the
// hit counter; slot contents are not cleared.
`include "event_breakpoint_match_table_core_defines.svh"

module event_breakpoint_match_table_core #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [5:0]  event_id,
    input  logic [63:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [63:0] armed_mask,
    output logic [31:0] hit_count
);
    import ebmt_pkg::*;

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PASS1 = 2'd1;
    localparam logic [1:0] S_PASS2 = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    logic        chain_vld [0:MAX_ENTRIES];
    pkt_t        chain_pkt [0:MAX_ENTRIES];
    logic [MAX_ENTRIES:1] chain_vld_vec;
    logic        head_vld;
    pkt_t        head_pkt;
    pkt_t        done_pkt_reg;
    pkt_t        done_pkt_next;
    logic [31:0] hits_total_reg;
    logic [31:0] hits_total_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;
    logic [63:0] mask_reg;
    logic [63:0] mask_next;
    logic [31:0] hit_count_reg;
    logic [31:0] hit_count_next;
    logic [1:0]  done_status;
    logic        out_free;

    // The chain head is fed by the sequencer.
    assign chain_vld[0] = head_vld;
    assign chain_pkt[0] = head_pkt;

    // Chain of slot cells.
    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            ebmt_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .vld_in  (chain_vld[gi]),
                .pkt_in  (chain_pkt[gi]),
                .vld_out (chain_vld[gi+1]),
                .pkt_out (chain_pkt[gi+1])
            );
        end
        for (gi = 1; gi <= MAX_ENTRIES; gi++)
        begin : g_vec
            assign chain_vld_vec[gi] = chain_vld[gi];
        end
    endgenerate

    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    // Status of a finished transaction.
    always_comb
    begin
        case (done_pkt_reg.func)
            FN_CHECK:  done_status = done_pkt_reg.hit ? ST_OK : ST_MISS;
            FN_ARM:    done_status = done_pkt_reg.dup ? ST_MISS :
                                     (done_pkt_reg.claim ? ST_FULL : ST_OK);
            FN_DISARM: done_status = done_pkt_reg.dup ? ST_OK : ST_MISS;
            FN_CLEAR:  done_status = ST_OK;
            default:   done_status = ST_MISS;
        endcase
    end

    // Sequencer: feeds the chain head, collects the tail, loads the output.
    always_comb
    begin
        state_next      = state_reg;
        head_vld        = 1'b0;
        head_pkt        = chain_pkt[MAX_ENTRIES];
        done_pkt_next   = done_pkt_reg;
        hits_total_next = hits_total_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        mask_next       = mask_reg;
        hit_count_next  = hit_count_reg;
        case (state_reg)
            S_IDLE:
            begin
                head_pkt.pass2    = 1'b0;
                head_pkt.func     = func;
                head_pkt.event_id = event_id;
                head_pkt.value    = value;
                head_pkt.hit      = 1'b0;
                head_pkt.dup      = 1'b0;
                head_pkt.claim    = 1'b0;
                head_pkt.mask     = 64'd0;
                if (in_valid)
                begin
                    head_vld   = 1'b1;
                    state_next = S_PASS1;
                end
            end
            S_PASS1:
            begin
                // Second pass: an arm with no duplicate looks for a free slot.
                head_pkt.pass2 = 1'b1;
                head_pkt.claim = (chain_pkt[MAX_ENTRIES].func == FN_ARM) &&
                                 !chain_pkt[MAX_ENTRIES].dup;
                head_pkt.mask  = 64'd0;
                if (chain_vld[MAX_ENTRIES])
                begin
                    head_vld   = 1'b1;
                    state_next = S_PASS2;
                end
            end
            S_PASS2:
            begin
                if (chain_vld[MAX_ENTRIES])
                begin
                    done_pkt_next = chain_pkt[MAX_ENTRIES];
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    if ((done_pkt_reg.func == FN_CHECK) && done_pkt_reg.hit &&
                        (hits_total_reg != 32'hFFFF_FFFF))
                    begin
                        hits_total_next = hits_total_reg + 32'd1;
                    end
                    out_valid_next = 1'b1;
                    status_next    = done_status;
                    mask_next      = done_pkt_reg.mask;
                    hit_count_next = hits_total_next;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            hits_total_reg <= 32'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hits_total_reg <= hits_total_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        done_pkt_reg  <= done_pkt_next;
        status_reg    <= status_next;
        mask_reg      <= mask_next;
        hit_count_reg <= hit_count_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign armed_mask = mask_reg;
    assign hit_count  = hit_count_reg;

    // Checks on the sequencer and chain.
    `EBMT_ASSERT_NOW(a_single_pkt, 1'b1, $countones(chain_vld_vec) <= 1, "Two packets in chain.")
    `EBMT_ASSERT_NOW(a_idle_empty, state_reg == S_IDLE, chain_vld_vec == '0, "Chain busy in idle.")
    `EBMT_ASSERT_NEXT(a_hits_mono, 1'b1, hits_total_reg >= $past(hits_total_reg), "Hits fell.")
    `EBMT_ASSERT_NOW(a_status_code, out_valid_reg, status_reg <= ST_FULL, "Bad status code.")

endmodule

[hw/rtl/ebmt_cell.sv]
// One table slot of the breakpoint match chain, with its packet stage.
module ebmt_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vld_in,
    input  ebmt_pkg::pkt_t    pkt_in,
    output logic              vld_out,
    output ebmt_pkg::pkt_t    pkt_out
);
    import ebmt_pkg::*;

    logic        slot_valid_reg;
    logic        slot_valid_next;
    logic [5:0]  slot_ev_reg;
    logic [5:0]  slot_ev_next;
    logic [63:0] slot_filter_reg;
    logic [63:0] slot_filter_next;
    logic        vld_reg;
    pkt_t        pkt_reg;
    pkt_t        pkt_next;
    logic        ev_eq;
    logic        exact;
    logic        any_hit;

    // Local comparisons against the slot contents.
    assign ev_eq   = slot_valid_reg && (slot_ev_reg == pkt_in.event_id);
    assign exact   = ev_eq && (slot_filter_reg == pkt_in.value);
    assign any_hit = ev_eq && ((slot_filter_reg == 64'd0) || (slot_filter_reg == pkt_in.value));

    // Slot update and packet modification for both passes.
    always_comb
    begin
        pkt_next         = pkt_in;
        slot_valid_next  = slot_valid_reg;
        slot_ev_next     = slot_ev_reg;
        slot_filter_next = slot_filter_reg;
        if (vld_in)
        begin
            if (!pkt_in.pass2)
            begin
                case (pkt_in.func)
                    FN_CHECK:
                    begin
                        if (any_hit)
                        begin
                            pkt_next.hit = 1'b1;
                        end
                    end
                    FN_ARM:
                    begin
                        if (exact)
                        begin
                            pkt_next.dup = 1'b1;
                        end
                    end
                    FN_DISARM:
                    begin
                        // Only the first matching pair is removed.
                        if (exact && !pkt_in.dup)
                        begin
                            slot_valid_next = 1'b0;
                            pkt_next.dup    = 1'b1;
                        end
                    end
                    FN_CLEAR:
                    begin
                        slot_valid_next = 1'b0;
                    end
                    default:
                    begin
                        pkt_next = pkt_in;
                    end
                endcase
            end
            else
            begin
                // The first free slot along the chain takes a pending insertion.
                if ((pkt_in.func == FN_ARM) && pkt_in.claim && !slot_valid_reg)
                begin
                    slot_valid_next  = 1'b1;
                    slot_ev_next     = pkt_in.event_id;
                    slot_filter_next = pkt_in.value;
                    pkt_next.claim   = 1'b0;
                end
                if (slot_valid_next)
                begin
                    pkt_next.mask = pkt_in.mask | (64'd1 << slot_ev_next);
                end
            end
        end
    end

    // Control state of the cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            vld_reg        <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            vld_reg        <= vld_in;
        end
    end

    // Slot contents and packet payload.
    always_ff @(posedge clk)
    begin
        slot_ev_reg     <= slot_ev_next;
        slot_filter_reg <= slot_filter_next;
        pkt_reg         <= pkt_next;
    end

    assign vld_out = vld_reg;
    assign pkt_out = pkt_reg;

endmodule

[test/event_breakpoint_match_table_checker.sv]
// Checker that predicts and compares every breakpoint table transaction.
`timescale 1ns / 1ps

module event_breakpoint_match_table_checker #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  func,
    input  logic [5:0]  event_id,
    input  logic [63:0] value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  status,
    input  logic [63:0] armed_mask,
    input  logic [31:0] hit_count,
    output int          mismatch_count,
    output int          replies_due
);
    import ebmt_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] mask;
        logic [31:0] hits;
    } table_reply_t;

    // Shadow copy of the trigger table and the hit counter.
    logic        slot_live [TABLE_DEPTH];
    logic [5:0]  slot_ev   [TABLE_DEPTH];
    logic [63:0] slot_filt [TABLE_DEPTH];
    logic [31:0] hits_seen;

    table_reply_t expected_replies[$];

    // Returns the live slot holding exactly this pair, or -1.
    function automatic int find_pair(input logic [5:0] ev, input logic [63:0] filt);
        int found;
        found = -1;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (slot_live[i] && slot_ev[i] == ev && slot_filt[i] == filt)
                found = i;
        end
        return found;
    endfunction

    // Applies one request to the shadow table and queues the reply it must give.
    task automatic apply_request(input logic [1:0] op, input logic [5:0] ev,
                                 input logic [63:0] arg);
        table_reply_t reply;
        int           slot;
        logic         matched;
        reply.status = ST_MISS;
        matched = 1'b0;
        slot = -1;
        case (op)
            FN_CHECK:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (slot_live[i] && slot_ev[i] == ev &&
                        (slot_filt[i] == 64'd0 || slot_filt[i] == arg))
                        matched = 1'b1;
                end
                if (matched)
                begin
                    reply.status = ST_OK;
                    if (hits_seen != 32'hFFFF_FFFF)
                        hits_seen++;
                end
            end
            FN_ARM:
            begin
                // A duplicate pair is reported before a full table.
                if (find_pair(ev, arg) < 0)
                begin
                    for (int i = 0; i < TABLE_DEPTH; i++)
                    begin
                        if (slot < 0 && !slot_live[i])
                            slot = i;
                    end
                    if (slot < 0)
                        reply.status = ST_FULL;
                    else
                    begin
                        slot_live[slot] = 1'b1;
                        slot_ev[slot]   = ev;
                        slot_filt[slot] = arg;
                        reply.status    = ST_OK;
                    end
                end
            end
            FN_DISARM:
            begin
                slot = find_pair(ev, arg);
                if (slot >= 0)
                begin
                    slot_live[slot] = 1'b0;
                    reply.status    = ST_OK;
                end
            end
            default:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    slot_live[i] = 1'b0;
                reply.status = ST_OK;
            end
        endcase
        reply.mask = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (slot_live[i])
                reply.mask[slot_ev[i]] = 1'b1;
        end
        reply.hits = hits_seen;
        expected_replies.insert(expected_replies.size(), reply);
    endtask

    // Requests are predicted as they are taken; replies are compared in order.
    always @(posedge clk or negedge rst_n)
    begin
        table_reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                slot_live[i] = 1'b0;
                slot_ev[i]   = '0;
                slot_filt[i] = '0;
            end
            hits_seen = '0;
            expected_replies.delete();
            mismatch_count = 0;
            replies_due = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                apply_request(func, event_id, value);
            if (out_valid && out_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("reply with no request outstanding: status %0d mask %h hits %0d",
                           status, armed_mask, hit_count);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        mismatch_count++;
                    end
                    if (armed_mask !== want.mask)
                    begin
                        $error("armed_mask: expected %h, actual %h", want.mask, armed_mask);
                        mismatch_count++;
                    end
                    if (hit_count !== want.hits)
                    begin
                        $error("hit_count: expected %0d, actual %0d", want.hits, hit_count);
                        mismatch_count++;
                    end
                end
            end
            replies_due = expected_replies.size();
        end
    end

endmodule

[test/event_breakpoint_match_table_core_tb.sv]
// Stimulus and verdict for the breakpoint match table.
`timescale 1ns / 1ps

module event_breakpoint_match_table_core_tb;
    import ebmt_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int LATENCY      = 2 * TABLE_DEPTH + 2;
    localparam int RANDOM_ITEMS = 1850;
    localparam int LONG_HOLD    = 300;
    localparam int TIMEOUT_NS   = 12_000_000;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [5:0]  event_id;
    logic [63:0] value;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [63:0] armed_mask;
    logic [31:0] hit_count;
    int          mismatch_count;
    int          replies_due;

    // Long receiver hold-offs asked for by the sender and served by the receiver.
    int hold_requests = 0;
    int holds_served  = 0;
    int burst_left    = 1;

    // Pairs recently armed, so that checks and disarms often hit the table.
    logic [69:0] armed_pairs[$];

    event_breakpoint_match_table_core #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .event_id  (event_id),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .armed_mask(armed_mask),
        .hit_count (hit_count)
    );

    event_breakpoint_match_table_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .event_id      (event_id),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .armed_mask    (armed_mask),
        .hit_count     (hit_count),
        .mismatch_count(mismatch_count),
        .replies_due   (replies_due)
    );

    // Clock with an 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Offers one transaction and holds it until taken; bursts end in a random gap.
    task automatic send_request(input logic [1:0] op, input logic [5:0] ev,
                                input logic [63:0] arg);
        func     = op;
        event_id = ev;
        value    = arg;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 70))
                @(negedge clk);
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(30, 60);
            else
                burst_left = $urandom_range(1, 12);
        end
    endtask

    // Stops offering and waits until every outstanding reply has arrived.
    task automatic wait_for_replies();
        in_valid = 1'b0;
        while (replies_due != 0)
            @(negedge clk);
    endtask

    // Receiver: stalls on changing patterns, with long hold-offs on request.
    initial
    begin
        int         mode;
        int         span;
        logic [7:0] pattern;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode    = $urandom_range(0, 3);
            pattern = 8'($urandom);
            span    = $urandom_range(20, 120);
            repeat (span)
            begin
                @(negedge clk);
                if (holds_served < hold_requests)
                begin
                    out_ready = 1'b0;
                    repeat (LONG_HOLD)
                        @(negedge clk);
                    holds_served++;
                end
                case (mode)
                    0: out_ready = 1'b1;
                    1: out_ready = 1'($urandom_range(0, 1));
                    2:
                    begin
                        out_ready = pattern[0];
                        pattern   = {pattern[0], pattern[7:1]};
                    end
                    default: out_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Ends the run if the block stops making progress.
    initial
    begin
        #TIMEOUT_NS;
        $display("simulation failed");
        $finish;
    end

    // Reset, directed cases, random traffic and the verdict.
    initial
    begin
        int          pick;
        logic [69:0] pair;
        logic [5:0]  ev;
        logic [63:0] arg;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        func     = FN_CHECK;
        event_id = '0;
        value    = '0;
        repeat (9)
            @(negedge clk);
        rst_n = 1'b1;

        // Clearing and checking an empty table.
        send_request(FN_CLEAR, 6'd0, 64'd0);
        send_request(FN_CHECK, 6'd0, 64'd0);
        // Wildcard and all-ones filters at both ends of the event range.
        send_request(FN_ARM, 6'd0, 64'd0);
        send_request(FN_ARM, 6'd0, 64'd0);
        send_request(FN_ARM, 6'd63, ALL_ONES);
        send_request(FN_CHECK, 6'd63, ALL_ONES);
        send_request(FN_CHECK, 6'd63, 64'd0);
        send_request(FN_CHECK, 6'd0, {$urandom, $urandom});
        // A zero filter does not remove a pair armed with another filter.
        send_request(FN_DISARM, 6'd63, 64'd0);
        // Fill the table, then try a new pair and a duplicate while full.
        for (int i = 1; i <= TABLE_DEPTH - 2; i++)
            send_request(FN_ARM, 6'(i), {$urandom, $urandom});
        send_request(FN_ARM, 6'd20, 64'd5);
        send_request(FN_ARM, 6'd63, ALL_ONES);
        send_request(FN_DISARM, 6'd63, ALL_ONES);
        send_request(FN_CLEAR, 6'd0, 64'd0);
        wait_for_replies();

        // Random traffic centred on a few events and filters.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 400 || n == 1300)
                hold_requests++;
            if (n % 300 == 299)
                wait_for_replies();

            if ($urandom_range(0, 9) < 7)
                ev = 6'($urandom_range(0, 5));
            else
                ev = 6'($urandom_range(0, 63));
            pick = $urandom_range(0, 9);
            if (pick < 3)
                arg = 64'd0;
            else if (pick < 6)
                arg = 64'($urandom_range(1, 3));
            else
                arg = {$urandom, $urandom};
            if (armed_pairs.size() != 0)
                pair = armed_pairs[$urandom_range(0, armed_pairs.size() - 1)];
            else
                pair = {ev, arg};

            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                if ($urandom_range(0, 9) < 6)
                    send_request(FN_CHECK, pair[69:64],
                                 ($urandom_range(0, 1) != 0) ? pair[63:0] : arg);
                else
                    send_request(FN_CHECK, ev, arg);
            end
            else if (pick < 75)
            begin
                armed_pairs.insert(armed_pairs.size(), {ev, arg});
                if (armed_pairs.size() > 32)
                    void'(armed_pairs.pop_front());
                send_request(FN_ARM, ev, arg);
            end
            else if (pick < 97)
            begin
                if ($urandom_range(0, 99) < 65)
                    send_request(FN_DISARM, pair[69:64], pair[63:0]);
                else
                    send_request(FN_DISARM, ev, arg);
            end
            else
            begin
                armed_pairs.delete();
                send_request(FN_CLEAR, ev, arg);
            end
        end

        // Drain, let the pipeline settle, then give the verdict.
        wait_for_replies();
        repeat (LATENCY + 8)
            @(negedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
